// ===== hw/rtl/tcw_pkg.sv =====
// Text console writer package: transaction payload types, state and register codes,
// character constants.
// No dependencies.
package tcw_pkg;

  localparam int ADDR_W = 14;  // row*columns+column for a 6-bit row and an 8-bit width

  localparam logic [7:0] BLANK      = 8'h20;
  localparam logic [7:0] ATTR       = 8'h07;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd25;
  localparam logic [7:0] LAST_CTRL  = 8'd31;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_VT = 8'd11;
  localparam logic [7:0] CH_FF = 8'd12;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SC_SIZE,
    ST_SC_COPY,
    ST_SC_BLANK,
    ST_PUT_ADDR,
    ST_PUT_WR,
    ST_CUR_ADDR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  byte_in;
    logic [11:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [12:0] cursor_address;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } out_item_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console writer: one put or read transaction at a time, result held in an output register.
// A printable put passes decode, address, write and cursor-address states, a read decode, read and
// cursor address, a control byte decode and cursor address; each then waits for the output register.
// A scroll copies and blanks one cell per cycle through the screen RAM port. The next transaction is
// taken while the last result waits. Reset: asynchronous; a clearing pass blanks all cells first.
// Depends on tcw_pkg and tcw_ram.
module text_console_char_writer #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcw_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = (AW > 12) ? AW : 12;
  localparam int AD    = tcw_pkg::ADDR_W;

  tcw_pkg::state_e    state_q, state_d;
  logic [7:0]         cols_q;
  logic [5:0]         rows_q;
  logic [7:0]         col_q, col_d;
  logic [5:0]         row_q, row_d;
  tcw_pkg::in_item_t  item_q, item_d;
  logic               scr_q, scr_d;
  logic [7:0]         cell_q, cell_d;
  logic               idx_ok_q, idx_ok_d;
  logic [AD-1:0]      cnt_q, cnt_d;
  logic [AD-1:0]      lim_q, lim_d;
  logic               pend_q, pend_d;
  logic [AD-1:0]      pend_addr_q, pend_addr_d;
  logic [AD-1:0]      addr_q, addr_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::out_item_t out_q, out_d;

  logic [7:0]    w;
  logic [5:0]    h;
  logic [AD-1:0] mac;
  logic [AD-1:0] rd_next;
  logic [AD-1:0] blank_end;
  logic          nl_scroll;
  logic [5:0]    nl_row;
  logic [IW-1:0] idx_w;
  logic          idx_in_range;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // effective screen size
  always_comb begin
    w = cols_q;
    if (cols_q == 8'd0) begin
      w = 8'd1;
    end else if ({1'b0, cols_q} > 9'(MAX_COLUMNS)) begin
      w = 8'(MAX_COLUMNS);
    end
    h = rows_q;
    if (rows_q == 6'd0) begin
      h = 6'd1;
    end else if ({1'b0, rows_q} > 7'(MAX_ROWS)) begin
      h = 6'(MAX_ROWS);
    end
  end

  // shared multiply-add: row*width+column
  assign mac       = AD'(row_q) * AD'(w) + AD'(col_q);
  assign rd_next   = cnt_q + AD'(w);
  assign blank_end = lim_q + AD'(w);
  assign nl_scroll = ({1'b0, row_q} + 7'd1) >= {1'b0, h};
  assign nl_row    = nl_scroll ? (h - 6'd1) : (row_q + 6'd1);
  assign idx_w        = IW'(item_q.cell_index);
  assign idx_in_range = {1'b0, idx_w} < (IW+1)'(CELLS);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    item_d      = item_q;
    scr_d       = scr_q;
    cell_d      = cell_q;
    idx_ok_d    = idx_ok_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    addr_d      = addr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AW-1:0];
    ram_wdata   = tcw_pkg::BLANK;
    ram_re      = 1'b0;
    ram_raddr   = rd_next[AW-1:0];

    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + AD'(1);
        if (cnt_q == AD'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          scr_d   = 1'b0;
          cell_d  = 8'd0;
          if (row_q >= h) begin
            row_d = h - 6'd1;
          end
          state_d = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        if (item_q.cmd == tcw_pkg::CMD_READ) begin
          ram_re    = 1'b1;
          ram_raddr = idx_w[AW-1:0];
          idx_ok_d  = idx_in_range;
          state_d   = tcw_pkg::ST_READ;
        end else begin
          state_d = tcw_pkg::ST_CUR_ADDR;
          case (item_q.byte_in) inside
            tcw_pkg::CH_LF, tcw_pkg::CH_VT, tcw_pkg::CH_FF: begin
              col_d = 8'd0;
              row_d = nl_row;
              if (nl_scroll) begin
                scr_d   = 1'b1;
                state_d = tcw_pkg::ST_SC_SIZE;
              end
            end
            tcw_pkg::CH_CR: begin
              col_d = 8'd0;
            end
            tcw_pkg::CH_BS: begin
              if (col_q == 8'd0) begin
                col_d = 8'd0;
              end else if ((col_q - 8'd1) >= w) begin
                col_d = w - 8'd1;
              end else begin
                col_d = col_q - 8'd1;
              end
            end
            default: begin
              if (item_q.byte_in > tcw_pkg::LAST_CTRL) begin
                state_d = tcw_pkg::ST_PUT_ADDR;
                if (col_q >= w) begin
                  col_d = 8'd0;
                  row_d = nl_row;
                  if (nl_scroll) begin
                    scr_d   = 1'b1;
                    state_d = tcw_pkg::ST_SC_SIZE;
                  end
                end
              end
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        cell_d  = idx_ok_q ? ram_rdata : tcw_pkg::BLANK;
        state_d = tcw_pkg::ST_CUR_ADDR;
      end
      tcw_pkg::ST_SC_SIZE: begin
        // row is the last row and column 0 here, so mac gives the moved cell count
        lim_d   = mac;
        cnt_d   = '0;
        pend_d  = 1'b0;
        state_d = tcw_pkg::ST_SC_COPY;
      end
      tcw_pkg::ST_SC_COPY: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (cnt_q < lim_q) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = cnt_q;
          cnt_d       = cnt_q + AD'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = tcw_pkg::ST_SC_BLANK;
        end
      end
      tcw_pkg::ST_SC_BLANK: begin
        if (cnt_q < blank_end) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + AD'(1);
        end else begin
          cnt_d   = '0;
          state_d = (item_q.byte_in > tcw_pkg::LAST_CTRL) ? tcw_pkg::ST_PUT_ADDR
                                                          : tcw_pkg::ST_CUR_ADDR;
        end
      end
      tcw_pkg::ST_PUT_ADDR: begin
        addr_d  = mac;
        state_d = tcw_pkg::ST_PUT_WR;
      end
      tcw_pkg::ST_PUT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q[AW-1:0];
        ram_wdata = item_q.byte_in;
        col_d     = col_q + 8'd1;
        state_d   = tcw_pkg::ST_CUR_ADDR;
      end
      tcw_pkg::ST_CUR_ADDR: begin
        addr_d  = mac;
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.cursor_column  = col_q;
          out_d.cursor_row     = row_q[4:0];
          out_d.cursor_address = addr_q[12:0];
          out_d.scrolled       = scr_q;
          out_d.cell_char      = cell_q;
          out_d.cell_attr      = tcw_pkg::ATTR;
          out_valid_d          = 1'b1;
          state_d              = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      col_q       <= 8'd0;
      row_q       <= 6'd0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    scr_q       <= scr_d;
    cell_q      <= cell_d;
    idx_ok_q    <= idx_ok_d;
    lim_q       <= lim_d;
    pend_addr_q <= pend_addr_d;
    addr_q      <= addr_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcw_pkg::COLS_RESET;
      rows_q <= tcw_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcw_pkg::REG_COLUMNS: cols_q <= cfg_wdata_i;
        tcw_pkg::REG_ROWS:    rows_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != tcw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_char_writer.
module tcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tcw_pkg::out_item_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cell_attr == tcw_pkg::ATTR)
    else $error("attribute not fixed");

  // a scroll only comes from a put and leaves the cursor at column 0 or 1
  a_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |->
      out_data_o.cell_char == 8'd0 && out_data_o.cursor_column <= 8'd1)
    else $error("bad scroll result");

  a_row0_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cursor_row == 5'd0 |->
      out_data_o.cursor_address == 13'(out_data_o.cursor_column))
    else $error("cursor address wrong on first row");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (.*);

// ===== tb/text_console_char_writer_test.sv =====
// Self-checking bench for text_console_char_writer: a queue-fed driver, a monitor and a
// console predictor with its own screen store; directed then random transactions.
// Depends on tcw_pkg and the text_console_char_writer RTL.
module text_console_char_writer_test;
  import tcw_pkg::*;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 54;
  localparam int STEADY_PH   = 5;
  localparam int IDLE_PCT    = 21;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  // predictor state
  logic [7:0]  screen_cells [CELLS];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [7:0]  width_reg  = COLS_RESET;
  logic [5:0]  height_reg = ROWS_RESET;

  in_item_t    commands_q[$];
  out_item_t   pending_results[$];
  out_item_t   predicted;
  out_item_t   wanted;
  bit          steady = 1'b0;

  int unsigned mismatches = 0;
  int unsigned n_puts = 0;
  int unsigned n_reads = 0;
  int unsigned n_scrolls = 0;

  int unsigned width_set [PHASES] = '{0, 1, 255, 128, 5, 12, 40, 7, 20, 255, 80, 2, 16, 3};
  int unsigned height_set[PHASES] = '{0, 1, 63, 32, 3, 4, 8, 2, 63, 1, 25, 5, 16, 0};

  text_console_char_writer #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned eff_width();
    if (width_reg == 8'd0) return 1;
    if (width_reg > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 6'd0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return 32'(height_reg);
  endfunction

  // new line; scrolls the active area when already on the last row
  function automatic bit advance_line(int unsigned w, int unsigned h);
    cursor_col = 0;
    if (cursor_row + 1 < h) begin
      cursor_row++;
      return 1'b0;
    end
    cursor_row = h - 1;
    for (int unsigned i = 0; i < w * (h - 1); i++) screen_cells[i] = screen_cells[i + w];
    for (int unsigned i = 0; i < w; i++) screen_cells[w * (h - 1) + i] = BLANK;
    return 1'b1;
  endfunction

  function automatic out_item_t console_apply(in_item_t it);
    int unsigned w;
    int unsigned h;
    out_item_t   res;
    w = eff_width();
    h = eff_height();
    res = '0;
    res.cell_attr = ATTR;
    if (cursor_row >= h) cursor_row = h - 1;
    if (it.cmd == CMD_READ) begin
      res.cell_char = screen_cells[it.cell_index];
    end else if (it.byte_in == CH_LF || it.byte_in == CH_VT || it.byte_in == CH_FF) begin
      res.scrolled = advance_line(w, h);
    end else if (it.byte_in == CH_CR) begin
      cursor_col = 0;
    end else if (it.byte_in == CH_BS) begin
      // column left beyond a shrunk width clamps to the last column
      if (cursor_col > w) cursor_col = w - 1;
      else if (cursor_col != 0) cursor_col--;
    end else if (it.byte_in > LAST_CTRL) begin
      if (cursor_col >= w) res.scrolled = advance_line(w, h);
      screen_cells[cursor_row * w + cursor_col] = it.byte_in;
      cursor_col++;
    end
    res.cursor_column  = 8'(cursor_col);
    res.cursor_row     = 5'(cursor_row);
    res.cursor_address = 13'(cursor_row * w + cursor_col);
    return res;
  endfunction

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned pick;
    it.cmd        = CMD_PUT;
    it.byte_in    = 8'($urandom_range(255, 32));
    it.cell_index = 12'($urandom_range(CELLS - 1));
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.cmd = CMD_READ;
    end else if (pick < 20) begin
      it.cmd        = CMD_READ;
      it.cell_index = 12'($urandom_range(eff_width() * eff_height() - 1));
    end else if (pick < 30) begin
      case ($urandom_range(2))
        0: it.byte_in = CH_LF;
        1: it.byte_in = CH_VT;
        default: it.byte_in = CH_FF;
      endcase
    end else if (pick < 35) begin
      it.byte_in = CH_CR;
    end else if (pick < 40) begin
      it.byte_in = CH_BS;
    end else if (pick < 44) begin
      it.byte_in = 8'($urandom_range(31));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [12:0] got, logic [12:0] want);
    mismatches++;
    $display("mismatch #%0d: %s got %0h expected %0h", mismatches, what, got, want);
  endtask

  task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic queue_put(logic [7:0] b);
    in_item_t it;
    it.cmd        = CMD_PUT;
    it.byte_in    = b;
    it.cell_index = 12'($urandom_range(CELLS - 1));
    commands_q.push_back(it);
  endtask

  task automatic queue_read(logic [11:0] idx);
    in_item_t it;
    it.cmd        = CMD_READ;
    it.byte_in    = 8'($urandom_range(255));
    it.cell_index = idx;
    commands_q.push_back(it);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (commands_q.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  task automatic set_geometry(logic [7:0] cols, logic [5:0] rows);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_COLUMNS;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ROWS;
    cfg_wdata_i <= {2'($urandom_range(3)), rows};  // upper bits are not part of the register
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_reg  = cols;
    height_reg = rows;
    @(negedge clk_i);
  endtask

  // driver; also applies each accepted transaction to the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted = console_apply(in_data_i);
        pending_results.push_back(predicted);
        if (in_data_i.cmd == CMD_READ) n_reads++;
        else n_puts++;
        if (predicted.scrolled) n_scrolls++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (commands_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_data_i  <= commands_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor; also drives the random output stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding", 13'd0, 13'd0);
        end else begin
          wanted = pending_results.pop_front();
          check_field("cursor_column", 13'(out_data_o.cursor_column),
                      13'(wanted.cursor_column));
          check_field("cursor_row", 13'(out_data_o.cursor_row), 13'(wanted.cursor_row));
          check_field("cursor_address", out_data_o.cursor_address, wanted.cursor_address);
          check_field("scrolled", 13'(out_data_o.scrolled), 13'(wanted.scrolled));
          check_field("cell_char", 13'(out_data_o.cell_char), 13'(wanted.cell_char));
          check_field("cell_attr", 13'(out_data_o.cell_attr), 13'(wanted.cell_attr));
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_cells[i] = BLANK;
    cursor_col = 0;
    cursor_row = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: blank store, every handled control byte, ignored bytes, byte extremes
    wait_idle();
    queue_read(12'd0);
    queue_read(12'd4095);
    queue_put(8'd72);
    queue_put(8'd255);
    queue_put(8'd32);
    queue_put(8'd0);
    queue_put(LAST_CTRL);
    queue_put(CH_BS);
    queue_put(CH_CR);
    queue_put(CH_LF);
    queue_put(CH_VT);
    queue_put(CH_FF);
    queue_read(12'd0);
    queue_read(12'd1);

    // tiny screen: wrap, scroll on wrap, backspace
    wait_idle();
    set_geometry(8'd3, 6'd2);
    for (int c = 97; c < 105; c++) queue_put(8'(c));
    queue_put(CH_BS);
    queue_read(12'd0);
    queue_read(12'd3);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady = (p == STEADY_PH);
      set_geometry(8'(width_set[p]), 6'(height_set[p]));
      for (int k = 0; k < ((p == STEADY_PH) ? 2 * PHASE_ITEMS : PHASE_ITEMS); k++)
        commands_q.push_back(random_command());
    end

    wait_idle();
    steady = 1'b0;
    repeat (20) @(posedge clk_i);

    $display("%0d puts (%0d with a scroll) and %0d cell reads over %0d screen geometries",
             n_puts, n_scrolls, n_reads, PHASES + 2);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("** text_console_char_writer: PASSED **");
    end else begin
      $display("** text_console_char_writer: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout: %0d transactions still queued, %0d results outstanding",
             commands_q.size(), pending_results.size());
    $display("** text_console_char_writer: FAILED **");
    $finish;
  end

endmodule
